FILE: rtl/bst_pkg.sv
// Package for the bounded set table: item and result types, operation and status codes.
// No dependencies.
package bst_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_CHANGED  = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	localparam int ITEM_VALUE_BITS = 32;
	localparam int COUNT_OUT_BITS  = 6;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [ITEM_VALUE_BITS-1:0] value;
	} in_t;

	typedef struct packed {
		logic                      was_present;
		logic [1:0]                status;
		logic [COUNT_OUT_BITS-1:0] count_after;
	} out_t;

	typedef struct packed {
		logic held;
		logic ins_here;
		logic rem_en;
	} cell_ctl_t;

endpackage

FILE: rtl/bst_cell.sv
// One cell of the set table: holds one entry, compares it with the probe value
// and shifts in its upper neighbor on a remove. Depends on bst_pkg.
module bst_cell import bst_pkg::*; #(
	parameter int VW = 32
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [VW-1:0] probe,
	input  logic [VW-1:0] above,
	input  logic          match_in,
	output logic          match_out,
	output logic [VW-1:0] entry
);

	logic [VW-1:0] entry_q;
	logic          hit;

	assign hit       = ctl.held && (entry_q == probe);
	assign match_out = match_in | hit;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_here) begin
			entry_q <= probe;
		end else if (ctl.rem_en && match_out) begin
			entry_q <= above;
		end
	end

endmodule

FILE: rtl/bounded_set_table.sv
// Top level of the bounded set table: input stage, count register and the row of cells.
// Depends on bst_pkg and bst_cell.
//
// Usage: an item (kind, value) is accepted at a rising edge where start is high
// and busy is low; busy stays low, so an item may be offered in every cycle.
// The item is registered, then in the following cycle every cell compares its
// entry with the value at once and the match ripples along the row, so an
// insert writes the cell at the current count and a remove shifts the cells
// at and above the match down by one in that same cycle.
// The result (was_present, status, count_after) is driven from the edge after
// the accepting edge, with done high for exactly one cycle. The receiver
// cannot stall, so results are never held. Throughput is one item per cycle,
// set by the compare and shift through the row of cells. Kind code 3 acts as
// a lookup. Reset clears the count, the pipeline and the result strobe; cell
// contents need no reset since only cells below the count are ever read.
module bounded_set_table import bst_pkg::*; #(
	parameter int CAPACITY   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	localparam int VW = (VALUE_BITS < ITEM_VALUE_BITS) ? VALUE_BITS : ITEM_VALUE_BITS;
	localparam int CW = $clog2(CAPACITY + 1);

	in_t           item_s1;
	logic          vld_s1;
	logic [CW-1:0] count_q;
	logic          done_q;
	out_t          result_q;

	logic [VW-1:0] probe;
	logic [VW-1:0] entry_w [CAPACITY];
	logic          match_w [CAPACITY+1];
	logic          present;
	logic          full;
	logic          do_ins;
	logic          do_rem;
	logic [CW-1:0] count_nxt;
	logic [1:0]    status_nxt;

	assign busy  = 1'b0;
	assign probe = item_s1.value[VW-1:0];
	assign full  = (count_q == CW'(CAPACITY));

	assign match_w[0] = 1'b0;
	assign present    = match_w[CAPACITY];

	assign do_ins = vld_s1 && (item_s1.kind == KIND_INSERT) && !present && !full;
	assign do_rem = vld_s1 && (item_s1.kind == KIND_REMOVE) && present;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t     ctl;
		logic [VW-1:0] above;

		assign ctl.held     = (CW'(i) < count_q);
		assign ctl.ins_here = do_ins && (CW'(i) == count_q);
		assign ctl.rem_en   = do_rem;

		if (i == CAPACITY - 1) begin : g_top
			assign above = entry_w[i];
		end else begin : g_mid
			assign above = entry_w[i+1];
		end

		bst_cell #(.VW(VW)) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.probe     (probe),
			.above     (above),
			.match_in  (match_w[i]),
			.match_out (match_w[i+1]),
			.entry     (entry_w[i])
		);
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_NOCHANGE;
		if (do_ins) begin
			count_nxt  = count_q + CW'(1);
			status_nxt = ST_CHANGED;
		end else if (do_rem) begin
			count_nxt  = count_q - CW'(1);
			status_nxt = ST_CHANGED;
		end else if (item_s1.kind == KIND_INSERT && !present && full) begin
			status_nxt = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			done_q  <= vld_s1;
			if (vld_s1) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
		if (vld_s1) begin
			result_q.was_present <= present;
			result_q.status      <= status_nxt;
			result_q.count_after <= COUNT_OUT_BITS'({{COUNT_OUT_BITS{1'b0}}, count_nxt});
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
